// File: hw/rtl/rshs_pkg.sv
`timescale 1ns / 1ps
package rshs_pkg;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       hit;
  } pixel_t;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_t;

  // hit test flags that ride with the partial products
  typedef struct packed {
    logic use_q;
    logic q_nz;
    logic c_neg;
  } hit_flags_t;

  localparam logic [15:0] CENTER_X_RST = 16'h0000;
  localparam logic [15:0] CENTER_Y_RST = 16'h0000;
  localparam logic [15:0] CENTER_Z_RST = 16'hF000;
  localparam logic [14:0] RADIUS_RST   = 15'd2048;

  localparam int DIV_STEPS = 33;
  localparam int SQ_STEPS  = 17;

  localparam int S_DIV0 = 4;
  localparam int S_HIT  = 7;
  localparam int S_SQ0  = S_DIV0 + DIV_STEPS;
  localparam int S_C1   = S_SQ0 + SQ_STEPS + 1;
  localparam int S_OUT  = S_C1 + 3;

  localparam logic [18:0] RN_BASE  = 19'd196608;
  localparam logic [22:0] GN_BASE  = 23'd5570560;
  localparam logic [14:0] COLOR_K  = 15'd25599;
  localparam logic [15:0] RECIP_R  = 16'd41944;
  localparam logic [18:0] RECIP_G  = 19'd429497;
  localparam logic [16:0] U_MAX    = 17'd65536;

endpackage

// File: hw/rtl/ray_sphere_hit_shader_core.sv
`timescale 1ns / 1ps
// Ray against sphere hit shader, one pixel color per ray.
// Input channel in_valid/in_ready/in_data carries one ray (origin and
// direction, signed fixed point). Output channel out_valid/out_ready/out_data
// carries the pixel: pure red on a hit, else a vertical sky gradient.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the sphere
// center (indexes 0..2) and radius (index 3); cfg_ready is always high and
// writes belong in idle time.
// Throughput: one ray per cycle while no stall on out_ready holds it. The
// depth is set by the restoring divider (33 stages, one quotient bit each)
// and the square root (17 stages, one result bit each) that form dy/|d|,
// plus the hit test and color stages.
// A stall on out_ready freezes the whole pipeline and drops in_ready in the
// same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the default sphere (center 0,0,-1,
// radius 0.5).
module ray_sphere_hit_shader_core
  import rshs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ray_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pixel_t      out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [15:0] cfg_data
);

  logic signed [15:0] center_x, center_y, center_z;
  logic [14:0]        radius;

  logic               en;
  logic [S_OUT:1]     vld;
  logic [S_C1-1:1]    dyneg_p;
  logic [S_C1-1:S_DIV0] az_p;
  logic [S_OUT-1:S_HIT] hit_p;
  logic               hit_comb;

  // stage 1
  logic signed [16:0] s1_ocx, s1_ocy, s1_ocz;
  logic signed [15:0] s1_dx, s1_dy, s1_dz;
  // stage 2
  logic signed [31:0] s2_xx, s2_yy, s2_zz;
  logic signed [32:0] s2_qx, s2_qy, s2_qz;
  logic signed [33:0] s2_cx, s2_cy, s2_cz;
  logic [29:0]        s2_rr;
  // stage 3
  logic [31:0]        s3_a;
  logic signed [34:0] s3_q;
  logic signed [34:0] s3_c;
  logic [30:0]        s3_dyy;
  // stage 4..6 hit test
  hit_flags_t         s4_hf, s5_hf, s6_hf;
  logic [33:0]        s4_qabs, s4_cm;
  logic [31:0]        s4_a;
  logic [33:0]        s5_qhh, s5_qhl, s5_qll;
  logic [33:0]        s5_ahh, s5_ahl, s5_alh, s5_all;
  logic [67:0]        s6_qsq, s6_ac;
  // divider and square root
  logic [32:0]        dv_r [0:DIV_STEPS];
  logic [32:0]        dv_q [0:DIV_STEPS];
  logic [31:0]        dv_a [0:DIV_STEPS-1];
  logic [16:0]        sq_u   [1:SQ_STEPS];
  logic [32:0]        sq_rem [1:SQ_STEPS];
  // color
  logic [16:0]        c1_mag;
  logic [18:0]        c1_rn;
  logic [22:0]        c1_gn;
  logic [32:0]        c2_pr;
  logic [37:0]        c2_pg;
  logic [28:0]        c3_mr;
  logic [36:0]        c3_mg;
  pixel_t             pix;

  assign en        = !vld[S_OUT] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[S_OUT];
  assign out_data  = pix;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= CENTER_X_RST;
      center_y <= CENTER_Y_RST;
      center_z <= CENTER_Z_RST;
      radius   <= RADIUS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_CENTER_Z: center_z <= cfg_data;
        REG_RADIUS:   radius   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_OUT-1:1], in_valid};
    end
  end

  assign hit_comb = s6_hf.use_q ? s6_hf.q_nz : (s6_hf.c_neg || (s6_qsq > s6_ac));

  always_ff @(posedge clk) begin
    if (en) begin
      dyneg_p <= {dyneg_p[S_C1-2:1], in_data.dir_y[15]};
      az_p    <= {az_p[S_C1-2:S_DIV0], (s3_a == 32'd0)};
      hit_p   <= {hit_p[S_OUT-2:S_HIT], hit_comb};

      s1_ocx <= 17'(in_data.origin_x) - 17'(center_x);
      s1_ocy <= 17'(in_data.origin_y) - 17'(center_y);
      s1_ocz <= 17'(in_data.origin_z) - 17'(center_z);
      s1_dx  <= in_data.dir_x;
      s1_dy  <= in_data.dir_y;
      s1_dz  <= in_data.dir_z;

      s2_xx <= 32'(s1_dx) * 32'(s1_dx);
      s2_yy <= 32'(s1_dy) * 32'(s1_dy);
      s2_zz <= 32'(s1_dz) * 32'(s1_dz);
      s2_qx <= 33'(s1_ocx) * 33'(s1_dx);
      s2_qy <= 33'(s1_ocy) * 33'(s1_dy);
      s2_qz <= 33'(s1_ocz) * 33'(s1_dz);
      s2_cx <= 34'(s1_ocx) * 34'(s1_ocx);
      s2_cy <= 34'(s1_ocy) * 34'(s1_ocy);
      s2_cz <= 34'(s1_ocz) * 34'(s1_ocz);
      s2_rr <= 30'(radius) * 30'(radius);

      s3_a   <= 32'(s2_xx) + 32'(s2_yy) + 32'(s2_zz);
      s3_q   <= 35'(s2_qx) + 35'(s2_qy) + 35'(s2_qz);
      s3_c   <= 35'(s2_cx) + 35'(s2_cy) + 35'(s2_cz) - $signed(35'(s2_rr));
      s3_dyy <= 31'(s2_yy);

      s4_hf.use_q <= (s3_a == 32'd0) || (s3_c == 35'sd0);
      s4_hf.q_nz  <= (s3_q != 35'sd0);
      s4_hf.c_neg <= s3_c[34];
      s4_qabs     <= s3_q[34] ? 34'(-s3_q) : 34'(s3_q);
      s4_cm       <= s3_c[33:0];
      s4_a        <= s3_a;

      // q^2 and a*c split into 17 bit halves
      s5_hf  <= s4_hf;
      s5_qhh <= 34'(s4_qabs[33:17]) * 34'(s4_qabs[33:17]);
      s5_qhl <= 34'(s4_qabs[33:17]) * 34'(s4_qabs[16:0]);
      s5_qll <= 34'(s4_qabs[16:0]) * 34'(s4_qabs[16:0]);
      s5_ahh <= 34'(s4_a[31:17]) * 34'(s4_cm[33:17]);
      s5_ahl <= 34'(s4_a[31:17]) * 34'(s4_cm[16:0]);
      s5_alh <= 34'(s4_a[16:0]) * 34'(s4_cm[33:17]);
      s5_all <= 34'(s4_a[16:0]) * 34'(s4_cm[16:0]);

      s6_hf  <= s5_hf;
      s6_qsq <= (68'(s5_qhh) << 34) + (68'(s5_qhl) << 18) + 68'(s5_qll);
      s6_ac  <= (68'(s5_ahh) << 34) + ((68'(s5_ahl) + 68'(s5_alh)) << 17)
                + 68'(s5_all);

      // divider starts with dy^2 already shifted in past the leading zeros
      dv_r[0] <= 33'(s3_dyy);
      dv_q[0] <= '0;
      dv_a[0] <= s3_a;
    end
  end

  // restoring divider: floor(dy^2 * 2^32 / a), one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic        ge;
    logic [32:0] rem;
    always_comb begin
      ge  = dv_r[j] >= {1'b0, dv_a[j]};
      rem = ge ? dv_r[j] - {1'b0, dv_a[j]} : dv_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j+1] <= {rem[31:0], 1'b0};
        dv_q[j+1] <= {dv_q[j][31:0], ge};
      end
    end
    if (j < DIV_STEPS - 1) begin : g_a
      always_ff @(posedge clk) begin
        if (en) begin
          dv_a[j+1] <= dv_a[j];
        end
      end
    end
  end

  // digit by digit square root, remainder form, one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam int B = SQ_STEPS - 1 - k;
    logic [16:0] u_cur;
    logic [32:0] r_cur;
    logic [34:0] inc;
    logic        ge;
    if (k == 0) begin : g_first
      assign u_cur = '0;
      assign r_cur = dv_q[DIV_STEPS];
    end else begin : g_rest
      assign u_cur = sq_u[k];
      assign r_cur = sq_rem[k];
    end
    always_comb begin
      inc = (35'(u_cur) << (B + 1)) + (35'(1) << (2 * B));
      ge  = {2'b00, r_cur} >= inc;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k+1] <= ge ? 33'({2'b00, r_cur} - inc) : r_cur;
        sq_u[k+1]   <= ge ? (u_cur | (17'(1) << B)) : u_cur;
      end
    end
  end

  always_comb begin
    c1_mag = az_p[S_C1-1] ? 17'd0 : sq_u[SQ_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dyneg_p[S_C1-1]) begin
        c1_rn <= RN_BASE + 19'(c1_mag);
        c1_gn <= GN_BASE + ((23'(c1_mag) << 4) - 23'(c1_mag));
      end else begin
        c1_rn <= RN_BASE - 19'(c1_mag);
        c1_gn <= GN_BASE - ((23'(c1_mag) << 4) - 23'(c1_mag));
      end

      c2_pr <= 33'(c1_rn) * 33'(COLOR_K);
      c2_pg <= 38'(c1_gn) * 38'(COLOR_K);

      // divide by 400*2^16 and 10000*2^16 via shift and reciprocal
      c3_mr <= 29'(c2_pr[32:20]) * 29'(RECIP_R);
      c3_mg <= 37'(c2_pg[37:20]) * 37'(RECIP_G);

      if (hit_p[S_OUT-1]) begin
        pix.red   <= 8'd255;
        pix.green <= 8'd0;
        pix.blue  <= 8'd0;
        pix.hit   <= 1'b1;
      end else begin
        pix.red   <= c3_mr[27:20];
        pix.green <= c3_mg[35:28];
        pix.blue  <= 8'd255;
        pix.hit   <= 1'b0;
      end
    end
  end

  a_hit_red: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> out_data.red == 8'd255 && out_data.green == 8'd0
      && out_data.blue == 8'd0)
    else $error("hit beat is not pure red");

  a_sky_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.red >= 8'd127 && out_data.green >= 8'd179
      && out_data.blue == 8'd255)
    else $error("sky gradient out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");

  a_sqrt_bound: assert property (@(posedge clk) disable iff (rst)
    vld[S_C1-1] && !az_p[S_C1-1] |-> sq_u[SQ_STEPS] <= U_MAX)
    else $error("dy/|d| magnitude above one");

endmodule
